// ----- sv/rfra_pkg.sv -----
// package: shared constants, types and crc helper for the frame replay analyzer
`timescale 1ns / 1ps
package rfra_pkg;
    localparam int FRAME_SLOTS_DEF = 64;
    localparam int MAX_PULSES_DEF  = 512;
    localparam logic [24:0] SUM_MAX = 25'h1FF_FFFF;

    typedef enum logic [1:0] {
        OP_PULSE  = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_GAP      = 3'd0,
        CFG_MAXP     = 3'd1,
        CFG_MINP     = 3'd2,
        CFG_ROLLWIN  = 3'd3,
        CFG_ROLLBACK = 3'd4
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_CRC, S_CLOSE, S_DIV, S_SCAN_I, S_RD_I, S_RD_J, S_CMP, S_RD_ROLL,
        S_ROLL, S_TOGGLE_RD, S_TOGGLE_WR, S_OUT
    } t_state;

    // one crc byte step, reflected polynomial, ones-complement on both sides
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        end
        return ~r;
    endfunction
endpackage

// ----- sv/rke_frame_replay_analyzer_top.sv -----
// top level: pulse framing, frame store and pairwise replay scan
//
//  channel | valid   | stall   | fields
//  in      | i_valid | o_stall | i_op i_level i_duration_us i_time_ms
//  out     | o_valid | i_stall | o_frame_done .. o_frames_stored
//  cfg     | i_cfg_we| -       | i_cfg_index i_cfg_data
//
// a pulse without close runs five crc byte steps, then the result word and idle
// a stored close adds a store write, one reciprocal multiply and a rescan of all
// n stored frames, pairwise; the single read port of each store serialises the scan
// a toggle of the newest frame adds a read and a write of its reaction bit, then the same rescan
// reset is synchronous; frame stores are not cleared
// o_stall is high from acceptance until the result word has been taken
`timescale 1ns / 1ps
module rke_frame_replay_analyzer_top #(
    parameter int FRAME_SLOTS = rfra_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_PULSES  = rfra_pkg::MAX_PULSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic        i_level,
    input  logic [31:0] i_duration_us,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_done,
    output logic [31:0] o_frame_hash,
    output logic [9:0]  o_frame_pulses,
    output logic [24:0] o_frame_duration_us,
    output logic [15:0] o_approx_bits,
    output logic        o_static_detected,
    output logic [31:0] o_static_hash,
    output logic        o_rollback_detected,
    output logic [31:0] o_rollback_gap_ms_res,
    output logic        o_rolling_detected,
    output logic [15:0] o_rolling_span_ms,
    output logic [6:0]  o_frames_stored
);
    localparam int SW = $clog2(FRAME_SLOTS);
    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int PW = $clog2(MAX_PULSES + 1);
    // reciprocal of 65 scaled by 2^30, exact for sums below 2^25
    localparam logic [23:0] RECIP_65 = 24'd16519105;

    // configuration registers
    logic [15:0] r_gap, r_maxp, r_rollwin;
    logic [9:0]  r_minp;
    logic [19:0] r_rollback;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 16'd4000; r_maxp <= 16'd30000; r_minp <= 10'd32;
            r_rollwin <= 16'd2500; r_rollback <= 20'd8000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rfra_pkg::CFG_GAP:      r_gap <= i_cfg_data[15:0];
                rfra_pkg::CFG_MAXP:     r_maxp <= i_cfg_data[15:0];
                rfra_pkg::CFG_MINP:     r_minp <= i_cfg_data[9:0];
                rfra_pkg::CFG_ROLLWIN:  r_rollwin <= i_cfg_data[15:0];
                rfra_pkg::CFG_ROLLBACK: r_rollback <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] m_time [FRAME_SLOTS];
    logic [31:0] m_hash [FRAME_SLOTS];
    logic        m_react [FRAME_SLOTS];
    logic        we_frame, we_react;
    logic [SW-1:0] wr_slot, rd_slot;
    logic [31:0] rd_time, rd_hash;
    logic        rd_react;

    rfra_pkg::t_state r_st, n_st;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_crc, n_crc;
    logic [24:0]   r_sum, n_sum;
    logic [SW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_stored, n_stored;
    logic [1:0]    r_op;
    logic          r_level;
    logic [31:0]   r_dur, r_now;
    logic [2:0]    r_byte, n_byte;
    logic          r_pend_gap, n_pend_gap;
    // analysis results
    logic r_st_f, n_st_f, r_rb_f, n_rb_f, r_rl_f, n_rl_f;
    logic [31:0] r_st_h, n_st_h, r_rb_g, n_rb_g;
    logic [15:0] r_rl_s, n_rl_s;
    // scan indices and latched i entry
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [31:0] r_ti, n_ti, r_hi, n_hi;
    logic r_ri, n_ri;
    // frame result and quotient
    logic r_fd, n_fd;
    logic [31:0] r_fh, n_fh;
    logic [9:0]  r_fp, n_fp;
    logic [24:0] r_fs, n_fs, r_q, n_q;
    logic [48:0] div_p;

    // frame stores, one read port each shared by the scan
    always_ff @(posedge i_clk) begin
        if (we_frame) begin
            m_time[wr_slot] <= r_now;
            m_hash[wr_slot] <= r_crc;
        end
        if (we_frame || we_react) m_react[wr_slot] <= we_react ? ~rd_react : 1'b0;
        rd_time  <= m_time[rd_slot];
        rd_hash  <= m_hash[rd_slot];
        rd_react <= m_react[rd_slot];
    end

    function automatic logic [SW-1:0] slot(input logic [SW-1:0] base, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {1'b0, CW'(base)} + {1'b0, k};
        if (s >= (CW+1)'(FRAME_SLOTS)) s = s - (CW+1)'(FRAME_SLOTS);
        return s[SW-1:0];
    endfunction

    assign o_stall = (r_st != rfra_pkg::S_IDLE);

    // shared crc byte selection
    logic [7:0] crc_in;
    always_comb begin
        case (r_byte)
            3'd0: crc_in = r_dur[7:0];
            3'd1: crc_in = r_dur[15:8];
            3'd2: crc_in = r_dur[23:16];
            3'd3: crc_in = r_dur[31:24];
            default: crc_in = {7'd0, r_level};
        endcase
    end

    logic [25:0] sum_w;
    assign sum_w = {1'b0, r_sum} + {1'b0, r_dur[24:0]};
    // quotient by 65 through the scaled reciprocal
    assign div_p = r_fs * RECIP_65;

    // sequencer
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_crc = r_crc; n_sum = r_sum;
        n_oldest = r_oldest; n_stored = r_stored; n_byte = r_byte;
        n_pend_gap = r_pend_gap;
        n_st_f = r_st_f; n_st_h = r_st_h; n_rb_f = r_rb_f; n_rb_g = r_rb_g;
        n_rl_f = r_rl_f; n_rl_s = r_rl_s;
        n_i = r_i; n_j = r_j; n_ti = r_ti; n_hi = r_hi; n_ri = r_ri;
        n_fd = r_fd; n_fh = r_fh; n_fp = r_fp; n_fs = r_fs; n_q = r_q;
        we_frame = 1'b0; we_react = 1'b0;
        wr_slot = slot(r_oldest, r_stored); rd_slot = '0;
        unique case (r_st)
            rfra_pkg::S_IDLE: ;
            rfra_pkg::S_CRC: begin
                n_crc = rfra_pkg::crc_byte(r_crc, crc_in);
                n_byte = r_byte + 3'd1;
                if (r_byte == 3'd4) begin
                    n_sum = (sum_w[25] || r_dur[31:25] != 7'd0) ? rfra_pkg::SUM_MAX
                                                                : sum_w[24:0];
                    n_cnt = r_cnt + PW'(1);
                    n_st = r_pend_gap ? rfra_pkg::S_CLOSE : rfra_pkg::S_OUT;
                    n_pend_gap = 1'b0;
                end
            end
            rfra_pkg::S_CLOSE: begin
                // close frame in progress
                if ({{(32-PW){1'b0}}, r_cnt} < {22'd0, r_minp}) begin
                    n_cnt = '0; n_crc = '0; n_sum = '0;
                    n_st = (r_op == rfra_pkg::OP_PULSE && r_byte == 3'd0)
                           ? rfra_pkg::S_CRC : rfra_pkg::S_OUT;
                end else begin
                    if (r_stored == CW'(FRAME_SLOTS)) begin
                        n_oldest = slot(r_oldest, CW'(1));
                        wr_slot = r_oldest;
                        n_stored = r_stored;
                    end else begin
                        n_stored = r_stored + CW'(1);
                    end
                    we_frame = 1'b1;
                    n_fd = 1'b1; n_fh = r_crc; n_fp = 10'(r_cnt); n_fs = r_sum;
                    n_cnt = '0; n_crc = '0; n_sum = '0;
                    n_st = rfra_pkg::S_DIV;
                end
            end
            rfra_pkg::S_DIV: begin
                n_q = {6'd0, div_p[48:30]};
                n_st = rfra_pkg::S_SCAN_I;
                n_i = '0;
                n_st_f = 1'b0; n_st_h = '0; n_rb_f = 1'b0; n_rb_g = '0;
                n_rl_f = 1'b0; n_rl_s = '0;
            end
            rfra_pkg::S_SCAN_I: begin
                if (r_i >= r_stored) n_st = (r_op == rfra_pkg::OP_PULSE && r_byte == 3'd0)
                                            ? rfra_pkg::S_CRC : rfra_pkg::S_OUT;
                else begin
                    rd_slot = slot(r_oldest, r_i);
                    n_st = rfra_pkg::S_RD_I;
                end
            end
            rfra_pkg::S_RD_I: begin
                n_ti = rd_time; n_hi = rd_hash; n_ri = rd_react;
                if (r_i >= CW'(4) && !r_rl_f) begin
                    rd_slot = slot(r_oldest, r_i - CW'(4));
                    n_st = rfra_pkg::S_RD_ROLL;
                end else begin
                    n_j = '0;
                    n_st = rfra_pkg::S_RD_J;
                end
            end
            rfra_pkg::S_RD_ROLL: begin
                // hold the read address of the frame four back
                rd_slot = slot(r_oldest, r_i - CW'(4));
                n_st = rfra_pkg::S_ROLL;
            end
            rfra_pkg::S_ROLL: begin
                if (r_ti - rd_time <= {16'd0, r_rollwin}) begin
                    n_rl_f = 1'b1; n_rl_s = 16'(r_ti - rd_time);
                end
                n_j = '0;
                n_st = rfra_pkg::S_RD_J;
            end
            rfra_pkg::S_RD_J: begin
                if (r_j >= r_i) begin
                    n_i = r_i + CW'(1);
                    n_st = rfra_pkg::S_SCAN_I;
                end else begin
                    rd_slot = slot(r_oldest, r_j);
                    n_st = rfra_pkg::S_CMP;
                end
            end
            rfra_pkg::S_CMP: begin
                if (rd_hash == r_hi) begin
                    if (!r_st_f) begin n_st_f = 1'b1; n_st_h = r_hi; end
                    if (!r_rb_f && ((r_ti - rd_time >= {12'd0, r_rollback}) ||
                        (rd_react && r_ri && (r_i - r_j >= CW'(2))))) begin
                        n_rb_f = 1'b1; n_rb_g = r_ti - rd_time;
                    end
                end
                n_j = r_j + CW'(1);
                n_st = rfra_pkg::S_RD_J;
            end
            rfra_pkg::S_TOGGLE_RD: begin
                rd_slot = slot(r_oldest, r_stored - CW'(1));
                n_st = rfra_pkg::S_TOGGLE_WR;
            end
            rfra_pkg::S_TOGGLE_WR: begin
                wr_slot = slot(r_oldest, r_stored - CW'(1));
                we_react = 1'b1;
                n_i = '0;
                n_st_f = 1'b0; n_st_h = '0; n_rb_f = 1'b0; n_rb_g = '0;
                n_rl_f = 1'b0; n_rl_s = '0;
                n_st = rfra_pkg::S_SCAN_I;
            end
            rfra_pkg::S_OUT: if (!i_stall) n_st = rfra_pkg::S_IDLE;
            default: n_st = rfra_pkg::S_IDLE;
        endcase
    end

    // state and item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rfra_pkg::S_IDLE; r_cnt <= '0; r_crc <= '0; r_sum <= '0;
            r_oldest <= '0; r_stored <= '0; r_byte <= '0; r_pend_gap <= 1'b0;
            r_st_f <= 1'b0; r_st_h <= '0; r_rb_f <= 1'b0; r_rb_g <= '0;
            r_rl_f <= 1'b0; r_rl_s <= '0;
            r_fd <= 1'b0;
        end else if (r_st == rfra_pkg::S_IDLE) begin
            if (i_valid) begin
                r_op <= i_op; r_level <= i_level; r_now <= i_time_ms;
                r_fd <= 1'b0;
                r_byte <= '0;
                unique case (rfra_pkg::t_op'(i_op))
                    rfra_pkg::OP_PULSE: begin
                        r_dur <= (i_duration_us > {16'd0, r_maxp}) ? {16'd0, r_maxp}
                                                                    : i_duration_us;
                        r_pend_gap <= !i_level &&
                            ((i_duration_us > {16'd0, r_maxp} ? {16'd0, r_maxp}
                              : i_duration_us) >= {16'd0, r_gap});
                        r_st <= (r_cnt >= PW'(MAX_PULSES)) ? rfra_pkg::S_CLOSE
                                                           : rfra_pkg::S_CRC;
                    end
                    rfra_pkg::OP_TOGGLE:
                        r_st <= (r_stored != '0) ? rfra_pkg::S_TOGGLE_RD : rfra_pkg::S_OUT;
                    rfra_pkg::OP_CLEAR: begin
                        r_stored <= '0; r_oldest <= '0; r_cnt <= '0; r_crc <= '0;
                        r_sum <= '0;
                        r_st_f <= 1'b0; r_st_h <= '0; r_rb_f <= 1'b0; r_rb_g <= '0;
                        r_rl_f <= 1'b0; r_rl_s <= '0;
                        r_st <= rfra_pkg::S_OUT;
                    end
                    default: r_st <= rfra_pkg::S_OUT;
                endcase
            end
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_crc <= n_crc; r_sum <= n_sum;
            r_oldest <= n_oldest; r_stored <= n_stored; r_byte <= n_byte;
            r_pend_gap <= n_pend_gap;
            r_st_f <= n_st_f; r_st_h <= n_st_h; r_rb_f <= n_rb_f; r_rb_g <= n_rb_g;
            r_rl_f <= n_rl_f; r_rl_s <= n_rl_s;
            r_fd <= n_fd;
        end
    end

    // payload registers without reset; frame fields cleared when an input word is accepted
    always_ff @(posedge i_clk) begin
        if (r_st == rfra_pkg::S_IDLE) begin
            if (i_valid) begin
                r_fh <= '0; r_fp <= '0; r_fs <= '0; r_q <= '0;
            end
        end else begin
            r_i <= n_i; r_j <= n_j; r_ti <= n_ti; r_hi <= n_hi; r_ri <= n_ri;
            r_fh <= n_fh; r_fp <= n_fp; r_fs <= n_fs; r_q <= n_q;
        end
    end

    // result word
    assign o_valid = (r_st == rfra_pkg::S_OUT);
    assign o_frame_done = r_fd;
    assign o_frame_hash = r_fh;
    assign o_frame_pulses = r_fp;
    assign o_frame_duration_us = r_fs;
    assign o_approx_bits = r_q[15:0];
    assign o_static_detected = r_st_f;
    assign o_static_hash = r_st_h;
    assign o_rollback_detected = r_rb_f;
    assign o_rollback_gap_ms_res = r_rb_g;
    assign o_rolling_detected = r_rl_f;
    assign o_rolling_span_ms = r_rl_s;
    assign o_frames_stored = 7'(r_stored);

`ifndef NO_ASSERTIONS
    a_stored_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(FRAME_SLOTS)) else $error("store count overflow");
    a_flag_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_static_detected |-> o_static_hash == '0)
        else $error("static hash without flag");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("ready while result pending");
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_done |-> o_frame_pulses == '0)
        else $error("frame fields without frame");
`endif
endmodule

// ----- tb/rfra_replay_checker.sv -----
// checker: predicts each result word of the frame replay analyzer and compares it
`timescale 1ns / 1ps
module rfra_replay_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_op,
    input  logic        i_level,
    input  logic [31:0] i_duration_us,
    input  logic [31:0] i_time_ms,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_frame_done,
    input  logic [31:0] i_frame_hash,
    input  logic [9:0]  i_frame_pulses,
    input  logic [24:0] i_frame_duration_us,
    input  logic [15:0] i_approx_bits,
    input  logic        i_static_detected,
    input  logic [31:0] i_static_hash,
    input  logic        i_rollback_detected,
    input  logic [31:0] i_rollback_gap_ms_res,
    input  logic        i_rolling_detected,
    input  logic [15:0] i_rolling_span_ms,
    input  logic [6:0]  i_frames_stored,
    output int          o_mismatches,
    output int          o_words_in,
    output int          o_pending
);
    typedef struct packed {
        bit        done;
        bit [31:0] hash;
        bit [9:0]  pulses;
        bit [24:0] dur_sum;
        bit [15:0] approx;
        bit        stat;
        bit [31:0] stat_hash;
        bit        rollback;
        bit [31:0] rollback_gap;
        bit        rolling;
        bit [15:0] rolling_span;
        bit [6:0]  stored;
    } t_frame_report;

    // register copies
    bit [15:0] gap_us, maxp_us, win_ms;
    bit [9:0]  min_cnt;
    bit [19:0] rb_ms;

    // framing and store state
    int unsigned pulse_cnt;
    bit [31:0]   crc_run;
    bit [24:0]   sum_run;
    bit [31:0]   slot_time [rfra_pkg::FRAME_SLOTS_DEF];
    bit [31:0]   slot_hash [rfra_pkg::FRAME_SLOTS_DEF];
    bit          slot_react [rfra_pkg::FRAME_SLOTS_DEF];
    int unsigned oldest, stored;

    // scan findings
    bit        f_stat, f_rb, f_roll;
    bit [31:0] f_stat_hash, f_rb_gap, f_roll_span;

    t_frame_report reports_due [$];

    function automatic bit [31:0] crc_shift_byte(bit [31:0] crc, bit [7:0] b);
        bit [31:0] r;
        r = ~crc ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return ~r;
    endfunction

    function automatic int unsigned slot_at(int unsigned age);
        return (oldest + age) % rfra_pkg::FRAME_SLOTS_DEF;
    endfunction

    // pairwise replay scan over all stored frames, oldest first
    function automatic void scan_frames();
        bit [31:0] t, h, gap;
        int unsigned s, o;
        f_stat = 0; f_stat_hash = 0;
        f_rb = 0; f_rb_gap = 0;
        f_roll = 0; f_roll_span = 0;
        for (int unsigned i = 0; i < stored; i++) begin
            s = slot_at(i);
            t = slot_time[s];
            h = slot_hash[s];
            if (i >= 4 && !f_roll) begin
                gap = t - slot_time[slot_at(i - 4)];
                if (gap <= win_ms) begin
                    f_roll = 1;
                    f_roll_span = gap;
                end
            end
            for (int unsigned j = 0; j < i; j++) begin
                o = slot_at(j);
                if (slot_hash[o] == h) begin
                    gap = t - slot_time[o];
                    if (!f_stat) begin
                        f_stat = 1;
                        f_stat_hash = h;
                    end
                    if (!f_rb && (gap >= rb_ms ||
                                  (slot_react[o] && slot_react[s] && (i - j) >= 2))) begin
                        f_rb = 1;
                        f_rb_gap = gap;
                    end
                end
            end
        end
    endfunction

    function automatic void drop_running();
        pulse_cnt = 0; crc_run = 0; sum_run = 0;
    endfunction

    // close the frame being built; store it if long enough
    function automatic void close_frame(bit [31:0] now, ref t_frame_report rep);
        int unsigned s;
        if (pulse_cnt < min_cnt) begin
            drop_running();
            return;
        end
        if (stored >= rfra_pkg::FRAME_SLOTS_DEF) begin
            oldest = (oldest + 1) % rfra_pkg::FRAME_SLOTS_DEF;
            stored = rfra_pkg::FRAME_SLOTS_DEF - 1;
        end
        s = slot_at(stored);
        stored++;
        slot_time[s] = now;
        slot_hash[s] = crc_run;
        slot_react[s] = 0;
        rep.done = 1;
        rep.hash = crc_run;
        rep.pulses = pulse_cnt[9:0];
        rep.dur_sum = sum_run;
        rep.approx = 16'(sum_run / 65);
        drop_running();
        scan_frames();
    endfunction

    function automatic t_frame_report predict_word(rfra_pkg::t_op op, bit lvl,
                                                   bit [31:0] dur_raw, bit [31:0] now);
        t_frame_report rep;
        bit [31:0] dur;
        bit [32:0] acc;
        int unsigned s;
        rep = '0;
        dur = (dur_raw > maxp_us) ? {16'd0, maxp_us} : dur_raw;
        case (op)
            rfra_pkg::OP_PULSE: begin
                if (pulse_cnt >= rfra_pkg::MAX_PULSES_DEF) close_frame(now, rep);
                if (pulse_cnt < rfra_pkg::MAX_PULSES_DEF) begin
                    for (int k = 0; k < 4; k++) crc_run = crc_shift_byte(crc_run, dur[8*k +: 8]);
                    crc_run = crc_shift_byte(crc_run, {7'd0, lvl});
                    acc = {8'd0, sum_run} + {1'b0, dur};
                    sum_run = (acc > {8'd0, rfra_pkg::SUM_MAX}) ? rfra_pkg::SUM_MAX
                                                                : acc[24:0];
                    pulse_cnt++;
                end
                if (!lvl && dur >= gap_us) close_frame(now, rep);
            end
            rfra_pkg::OP_TOGGLE: begin
                if (stored > 0) begin
                    s = slot_at(stored - 1);
                    slot_react[s] = ~slot_react[s];
                    scan_frames();
                end
            end
            rfra_pkg::OP_CLEAR: begin
                stored = 0;
                oldest = 0;
                drop_running();
                scan_frames();
            end
            default: ;
        endcase
        rep.stat = f_stat;
        rep.stat_hash = f_stat_hash;
        rep.rollback = f_rb;
        rep.rollback_gap = f_rb_gap;
        rep.rolling = f_roll;
        rep.rolling_span = f_roll_span[15:0];
        rep.stored = stored[6:0];
        return rep;
    endfunction

    // registers, accepted words and predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_us = 16'd4000; maxp_us = 16'd30000; min_cnt = 10'd32;
            win_ms = 16'd2500; rb_ms = 20'd8000;
            drop_running();
            oldest = 0; stored = 0;
            scan_frames();
            reports_due.delete();
            o_words_in <= 0;
        end else begin
            if (i_cfg_we) begin
                case (rfra_pkg::t_cfg'(i_cfg_index))
                    rfra_pkg::CFG_GAP:      gap_us = i_cfg_data[15:0];
                    rfra_pkg::CFG_MAXP:     maxp_us = i_cfg_data[15:0];
                    rfra_pkg::CFG_MINP:     min_cnt = i_cfg_data[9:0];
                    rfra_pkg::CFG_ROLLWIN:  win_ms = i_cfg_data[15:0];
                    rfra_pkg::CFG_ROLLBACK: rb_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                reports_due.push_back(predict_word(rfra_pkg::t_op'(i_op), i_level,
                                                   i_duration_us, i_time_ms));
                o_words_in <= o_words_in + 1;
            end
        end
    end

    // result words against the oldest prediction
    always @(posedge i_clk) begin
        t_frame_report got, want;
        if (!i_rst_n) begin
            o_mismatches <= 0;
        end else if (i_out_valid && !i_out_stall) begin
            got = {i_frame_done, i_frame_hash, i_frame_pulses, i_frame_duration_us,
                   i_approx_bits, i_static_detected, i_static_hash, i_rollback_detected,
                   i_rollback_gap_ms_res, i_rolling_detected, i_rolling_span_ms,
                   i_frames_stored};
            if (reports_due.size() == 0) begin
                o_mismatches <= o_mismatches + 1;
                if (o_mismatches < 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                want = reports_due.pop_front();
                if (got != want) begin
                    o_mismatches <= o_mismatches + 1;
                    if (o_mismatches < 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp done=%0d hash=%h n=%0d sum=%0d apx=%0d",
                                 want.done, want.hash, want.pulses, want.dur_sum,
                                 want.approx);
                        $display("      st=%0d/%h rb=%0d/%0d rl=%0d/%0d fr=%0d",
                                 want.stat, want.stat_hash, want.rollback, want.rollback_gap,
                                 want.rolling, want.rolling_span, want.stored);
                        $display("  got done=%0d hash=%h n=%0d sum=%0d apx=%0d",
                                 got.done, got.hash, got.pulses, got.dur_sum, got.approx);
                        $display("      st=%0d/%h rb=%0d/%0d rl=%0d/%0d fr=%0d",
                                 got.stat, got.stat_hash, got.rollback, got.rollback_gap,
                                 got.rolling, got.rolling_span, got.stored);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) o_pending <= reports_due.size();
endmodule

// ----- tb/tb_rke_frame_replay_analyzer_top.sv -----
// testbench top: stimulus, idling, register phases and verdict for the frame replay analyzer
`timescale 1ns / 1ps
module tb_rke_frame_replay_analyzer_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic        i_level;
    logic [31:0] i_duration_us;
    logic [31:0] i_time_ms;
    logic        o_valid;
    logic        i_stall;
    logic        o_frame_done;
    logic [31:0] o_frame_hash;
    logic [9:0]  o_frame_pulses;
    logic [24:0] o_frame_duration_us;
    logic [15:0] o_approx_bits;
    logic        o_static_detected;
    logic [31:0] o_static_hash;
    logic        o_rollback_detected;
    logic [31:0] o_rollback_gap_ms_res;
    logic        o_rolling_detected;
    logic [15:0] o_rolling_span_ms;
    logic [6:0]  o_frames_stored;

    int mismatches, words_in, pending;
    bit quiet, hold_req;
    bit [31:0] now_ms;
    bit [15:0] gap_cur;
    bit [9:0]  minp_cur;
    int sent;

    rke_frame_replay_analyzer_top dut (.*);

    rfra_replay_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall), .i_op, .i_level, .i_duration_us, .i_time_ms,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_frame_done(o_frame_done), .i_frame_hash(o_frame_hash),
        .i_frame_pulses(o_frame_pulses), .i_frame_duration_us(o_frame_duration_us),
        .i_approx_bits(o_approx_bits), .i_static_detected(o_static_detected),
        .i_static_hash(o_static_hash), .i_rollback_detected(o_rollback_detected),
        .i_rollback_gap_ms_res(o_rollback_gap_ms_res),
        .i_rolling_detected(o_rolling_detected), .i_rolling_span_ms(o_rolling_span_ms),
        .i_frames_stored(o_frames_stored),
        .o_mismatches(mismatches), .o_words_in(words_in), .o_pending(pending)
    );

    initial i_clk = 0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1;
                repeat (300) @(negedge i_clk);
                hold_req = 0;
                i_stall <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_stall <= 0;
            end
        end
    end

    // offer one word and wait until it is taken; entered and left at a falling edge
    task automatic send_word(rfra_pkg::t_op op, bit lvl, bit [31:0] dur, bit [31:0] tms);
        int target;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        target = words_in + 1;
        i_valid <= 1;
        i_op <= op;
        i_level <= lvl;
        i_duration_us <= dur;
        i_time_ms <= tms;
        wait (words_in == target);
        @(negedge i_clk);
        sent++;
    endtask

    // drain all results, then let the block settle before touching registers
    task automatic drain();
        i_valid <= 0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic program_regs(bit [15:0] g, bit [15:0] m, bit [9:0] p, bit [15:0] w,
                                bit [19:0] r);
        i_cfg_we <= 1;
        i_cfg_index <= rfra_pkg::CFG_GAP;      i_cfg_data <= 20'(g); @(negedge i_clk);
        i_cfg_index <= rfra_pkg::CFG_MAXP;     i_cfg_data <= 20'(m); @(negedge i_clk);
        i_cfg_index <= rfra_pkg::CFG_MINP;     i_cfg_data <= 20'(p); @(negedge i_clk);
        i_cfg_index <= rfra_pkg::CFG_ROLLWIN;  i_cfg_data <= 20'(w); @(negedge i_clk);
        i_cfg_index <= rfra_pkg::CFG_ROLLBACK; i_cfg_data <= r;      @(negedge i_clk);
        i_cfg_we <= 0;
        @(negedge i_clk);
        gap_cur = g;
        minp_cur = p;
    endtask

    // advance the millisecond tick by a mix of zero, short and long steps, or jump it to a random value
    task automatic tick();
        case ($urandom_range(0, 5))
            0: now_ms += 0;
            1, 2: now_ms += $urandom_range(1, 600);
            3: now_ms += $urandom_range(2000, 3000);
            4: now_ms += $urandom_range(8000, 1_100_000);
            default: now_ms = $urandom;
        endcase
    endtask

    // one well-formed frame; a pattern number fixes its content so codes repeat
    task automatic send_frame(int pat);
        int n;
        n = minp_cur + pat % 3;
        for (int p = 0; p < n - 1; p++)
            send_word(rfra_pkg::OP_PULSE, 1, 32'((pat * 1237 + p * 97) & 32'hFFFF), now_ms);
        tick();
        send_word(rfra_pkg::OP_PULSE, 0, 32'(gap_cur) + 32'(pat), now_ms);
    endtask

    // random mix of frames, toggles, clears, noise and broken frames
    task automatic random_phase(int budget, bit clears);
        int start, r;
        start = sent;
        while (sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 62) send_frame($urandom_range(0, 3));
            else if (r < 74) send_word(rfra_pkg::OP_TOGGLE, 1'($urandom), $urandom, now_ms);
            else if (r < 78 && clears)
                send_word(rfra_pkg::OP_CLEAR, 1'($urandom), $urandom, now_ms);
            else if (r < 90) begin
                tick();
                send_word(rfra_pkg::OP_PULSE, 1'($urandom), $urandom, now_ms);
            end else if (r < 94)
                send_word(rfra_pkg::OP_NONE, 1'($urandom), $urandom, $urandom);
            else begin
                repeat ($urandom_range(1, 3))
                    send_word(rfra_pkg::OP_PULSE, 1, $urandom_range(0, 70000), now_ms);
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_index = rfra_pkg::CFG_GAP; i_cfg_data = 0;
        i_valid = 0; i_op = rfra_pkg::OP_PULSE; i_level = 0; i_duration_us = 0;
        i_time_ms = 0;
        quiet = 0; hold_req = 0; now_ms = 1000; sent = 0;
        gap_cur = 16'd4000; minp_cur = 10'd32;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // defaults: toggle with no frames, unused op, clear, clamp, short frame dropped
        send_word(rfra_pkg::OP_TOGGLE, 0, 0, 0);
        send_word(rfra_pkg::OP_NONE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rfra_pkg::OP_CLEAR, 0, 0, 0);
        send_word(rfra_pkg::OP_PULSE, 1, 0, 10);
        send_word(rfra_pkg::OP_PULSE, 1, 32'hFFFF_FFFF, 10);
        send_word(rfra_pkg::OP_PULSE, 0, 4000, 20);
        drain();

        // mostly one-pulse frames: repeats, reaction toggles, tick wrap, zero windows
        program_regs(16'd1, 16'hFFFF, 10'd1, 16'd0, 20'd0);
        send_word(rfra_pkg::OP_PULSE, 0, 5, 100);
        send_word(rfra_pkg::OP_PULSE, 0, 5, 100);
        send_word(rfra_pkg::OP_TOGGLE, 0, 0, 0);
        send_word(rfra_pkg::OP_PULSE, 0, 7, 200);
        send_word(rfra_pkg::OP_PULSE, 0, 5, 300);
        send_word(rfra_pkg::OP_TOGGLE, 1, 0, 0);
        send_word(rfra_pkg::OP_TOGGLE, 1, 0, 0);
        send_word(rfra_pkg::OP_PULSE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rfra_pkg::OP_PULSE, 0, 0, 0);
        send_word(rfra_pkg::OP_PULSE, 0, 1, 0);
        send_word(rfra_pkg::OP_PULSE, 0, 5, 400);
        drain();

        // more than a full store of frames to force eviction
        program_regs(16'd1, 16'd1, 10'd1, 16'd0, 20'd0);
        for (int f = 0; f < 70; f++) begin
            now_ms += $urandom_range(0, 3);
            send_word(rfra_pkg::OP_PULSE, 0, $urandom_range(1, 3), now_ms);
        end
        random_phase(45, 0);
        drain();

        program_regs(16'd3000, 16'd30000, 10'd2, 16'd2500, 20'd8000);
        random_phase(45, 1);
        drain();

        // receiver holds off while words keep coming
        program_regs(16'd200, 16'd1000, 10'd3, 16'hFFFF, 20'd1_000_000);
        hold_req = 1;
        random_phase(45, 1);
        drain();

        quiet = 1;
        program_regs(16'd5000, 16'd20000, 10'd4, 16'd100, 20'd50);
        random_phase(45, 1);
        drain();

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
